/* rtl/multi_pattern_dfa_scanner_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern DFA scanner
// Concurrent checks, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_DFA_SCANNER_ASSERT_SVH
`define MULTI_PATTERN_DFA_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPDS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPDS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mpds_pkg.sv */
// ----------------------------------------------------------------------------
// mpds_pkg
// Field widths, default sizes and operation codes of the DFA scanner.
// ----------------------------------------------------------------------------
package mpds_pkg;

	localparam int DEF_STATE_COUNT   = 1024;
	localparam int DEF_ALPHABET      = 256;
	localparam int DEF_PATTERN_COUNT = 256;
	localparam int DEF_MAX_CHAIN     = 16;

	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int STATE_W  = 10;
	localparam int PIDX_W   = 8;
	localparam int PVAL_W   = 9;
	localparam int PID_W    = 8;
	localparam int OFFSET_W = 16;

	// Padded widths used for index extension and range compares
	localparam int IDX_PAD_W = 16;
	localparam int CMP_W     = 17;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_SCAN     = 2'd0,
		OP_WR_TRANS = 2'd1,
		OP_WR_HEAD  = 2'd2,
		OP_WR_LINK  = 2'd3
	} op_t;

endpackage

/* rtl/multi_pattern_dfa_scanner.sv */
// ----------------------------------------------------------------------------
// multi_pattern_dfa_scanner
// Aho-Corasick scan engine over a software-built DFA held in on-chip tables.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | op byte_value restart state_index next_state
//          |                       | pattern_index pattern_value
//  out     | out_valid / out_ready | match_id offset last truncated
//
//  Table writes are taken in the idle state and leave the sequencer idle.
//  A scan byte goes through a transition read, a match head read, then one
//  match-link read per reported pattern, back to back.
//  Output stalls hold the chain walk; the input is taken again once the walk ends.
//  Reset clears the FSM, state (root), byte offset, chain count and out_valid;
//  the tables hold nothing defined until software writes them; no clearing pass.
//
`include "multi_pattern_dfa_scanner_assert.svh"

module multi_pattern_dfa_scanner #(
	parameter int STATE_COUNT   = mpds_pkg::DEF_STATE_COUNT,
	parameter int ALPHABET      = mpds_pkg::DEF_ALPHABET,
	parameter int PATTERN_COUNT = mpds_pkg::DEF_PATTERN_COUNT,
	parameter int MAX_CHAIN     = mpds_pkg::DEF_MAX_CHAIN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mpds_pkg::op_t                 op,
	input  logic [mpds_pkg::BYTE_W-1:0]   byte_value,
	input  logic                          restart,
	input  logic [mpds_pkg::STATE_W-1:0]  state_index,
	input  logic [mpds_pkg::STATE_W-1:0]  next_state,
	input  logic [mpds_pkg::PIDX_W-1:0]   pattern_index,
	input  logic [mpds_pkg::PVAL_W-1:0]   pattern_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mpds_pkg::PID_W-1:0]    match_id,
	output logic [mpds_pkg::OFFSET_W-1:0] offset,
	output logic                          last,
	output logic                          truncated
);
	import mpds_pkg::*;

	localparam int ST_AW    = $clog2(STATE_COUNT);
	localparam int PAT_AW   = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
	localparam int TT_DEPTH = STATE_COUNT * ALPHABET;
	localparam int TT_AW    = $clog2(TT_DEPTH);
	localparam int CNT_W    = $clog2(MAX_CHAIN + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_TRANS = 4'b0010,
		ST_HEAD  = 4'b0100,
		ST_WALK  = 4'b1000
	} fsm_t;

	// Table storage
	logic [STATE_W-1:0] tt_mem   [TT_DEPTH];
	logic [PVAL_W-1:0]  head_mem [STATE_COUNT];
	logic [PVAL_W-1:0]  link_mem [PATTERN_COUNT];

	logic [STATE_W-1:0] tt_rd_q;
	logic [PVAL_W-1:0]  head_rd_q;
	logic [PVAL_W-1:0]  link_rd_q;

	fsm_t               fsm_q;
	logic [STATE_W-1:0] state_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [OFFSET_W-1:0] pos_q;
	logic               root_q;
	logic [PVAL_W-1:0]  pend_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [PID_W-1:0]   out_id_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic               out_last_q;
	logic               out_trunc_q;

	logic               in_acc;
	logic               scan_acc;
	logic               tt_we;
	logic               head_we;
	logic               link_we;
	logic               byte_ok;
	logic [STATE_W-1:0] scan_state;
	logic [STATE_W-1:0] addr_state;
	logic [IDX_PAD_W-1:0] addr_state_pad;
	logic [TT_AW-1:0]   tt_addr;
	logic [IDX_PAD_W-1:0] si_pad;
	logic [IDX_PAD_W-1:0] pi_pad;
	logic [STATE_W-1:0] nxt_state;
	logic [IDX_PAD_W-1:0] nxt_pad;
	logic               cand_none;
	logic               follow_none;
	logic               at_max;
	logic               fin;
	logic               out_free;
	logic               emit;
	logic               link_re;
	logic [PVAL_W-1:0]  link_rd_id;
	logic [IDX_PAD_W-1:0] link_ra_pad;
	logic [OFFSET_W-1:0] base_offset;
	logic               cnt_in_range;

	assign in_ready = (fsm_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign scan_acc = in_acc && (op == OP_SCAN);

	assign byte_ok = (9'(byte_value) < 9'(ALPHABET));
	assign tt_we   = in_acc && (op == OP_WR_TRANS) && byte_ok
		&& (CMP_W'(state_index) < CMP_W'(STATE_COUNT))
		&& (CMP_W'(next_state) < CMP_W'(STATE_COUNT));
	assign head_we = in_acc && (op == OP_WR_HEAD)
		&& (CMP_W'(state_index) < CMP_W'(STATE_COUNT));
	assign link_we = in_acc && (op == OP_WR_LINK)
		&& (CMP_W'(pattern_index) < CMP_W'(PATTERN_COUNT));

	// Restart and out-of-range states fall back to the root
	always_comb begin
		scan_state = state_q;
		if (restart || (CMP_W'(state_q) >= CMP_W'(STATE_COUNT))) begin
			scan_state = '0;
		end
	end

	assign addr_state     = (op == OP_SCAN) ? scan_state : state_index;
	assign addr_state_pad = IDX_PAD_W'(addr_state);
	assign tt_addr        = TT_AW'(addr_state_pad[ST_AW-1:0]) * TT_AW'(ALPHABET)
		+ TT_AW'(byte_value);
	assign si_pad = IDX_PAD_W'(state_index);
	assign pi_pad = IDX_PAD_W'(pattern_index);

	// Next state once the transition read returns
	always_comb begin
		nxt_state = root_q ? '0 : tt_rd_q;
		if (CMP_W'(nxt_state) >= CMP_W'(STATE_COUNT)) begin
			nxt_state = '0;
		end
	end
	assign nxt_pad = IDX_PAD_W'(nxt_state);

	// Chain walk decisions
	assign cand_none   = (CMP_W'(head_rd_q) >= CMP_W'(PATTERN_COUNT));
	assign follow_none = (CMP_W'(link_rd_q) >= CMP_W'(PATTERN_COUNT));
	assign at_max      = (cnt_q == CNT_W'(MAX_CHAIN));
	assign fin         = follow_none || at_max;
	assign out_free    = !out_valid_q || out_ready;
	assign emit        = (fsm_q == ST_WALK) && out_free;
	assign link_re     = ((fsm_q == ST_HEAD) && !cand_none) || (emit && !fin);
	assign link_rd_id  = (fsm_q == ST_HEAD) ? head_rd_q : link_rd_q;
	assign link_ra_pad = IDX_PAD_W'(link_rd_id);

	assign base_offset = restart ? '0 : offset_q;

	assign cnt_in_range = (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_CHAIN));

	// Transition table: one port, write or read per cycle
	always_ff @(posedge clk) begin
		if (tt_we) begin
			tt_mem[tt_addr] <= next_state;
		end else if (scan_acc) begin
			tt_rd_q <= tt_mem[tt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[si_pad[ST_AW-1:0]] <= pattern_value;
		end
		if (fsm_q == ST_TRANS) begin
			head_rd_q <= head_mem[nxt_pad[ST_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[pi_pad[PAT_AW-1:0]] <= pattern_value;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra_pad[PAT_AW-1:0]];
		end
	end

	// Sequencer and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= ST_IDLE;
			state_q  <= '0;
			offset_q <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (fsm_q)
				ST_IDLE: begin
					if (scan_acc) begin
						offset_q <= (base_offset == OFFSET_MAX) ? base_offset
							: base_offset + OFFSET_W'(1);
						fsm_q    <= ST_TRANS;
					end
				end
				ST_TRANS: begin
					state_q <= nxt_state;
					fsm_q   <= ST_HEAD;
				end
				ST_HEAD: begin
					if (cand_none) begin
						fsm_q <= ST_IDLE;
					end else begin
						cnt_q <= CNT_W'(1);
						fsm_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (emit) begin
						if (fin) begin
							fsm_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					fsm_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-byte payload registers
	always_ff @(posedge clk) begin
		if (scan_acc) begin
			pos_q  <= base_offset;
			root_q <= !byte_ok;
		end
		if (fsm_q == ST_HEAD) begin
			pend_q <= head_rd_q;
		end else if (emit && !fin) begin
			pend_q <= link_rd_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_id_q     <= pend_q[PID_W-1:0];
			out_offset_q <= pos_q;
			out_last_q   <= fin;
			out_trunc_q  <= at_max && !follow_none;
		end
	end

	assign out_valid = out_valid_q;
	assign match_id  = out_id_q;
	assign offset    = out_offset_q;
	assign last      = out_last_q;
	assign truncated = out_trunc_q;

	`MPDS_ASSERT_NXT(a_scan_starts_walk, scan_acc, fsm_q == ST_TRANS, "scan did not start")
	`MPDS_ASSERT_IMP(a_cnt_bound, fsm_q == ST_WALK, cnt_in_range, "chain count out of bounds")
	`MPDS_ASSERT_IMP(a_trunc_on_last, out_valid, !truncated || last, "truncated without last")
	`MPDS_ASSERT_NXT(a_offset_hold, fsm_q != ST_IDLE, $stable(offset_q), "offset moved mid-scan")

endmodule
